// ===== sv/mofrp_pkg.sv =====
// Package for the multichannel oldest-first request pool.
// Holds the request record, status and sequencer codes, and fixed widths.
// No dependencies.
package mofrp_pkg;

  // fixed widths of the item fields
  localparam int unsigned AGE_W     = 32;
  localparam int unsigned OUT_CH_W  = 3;
  localparam int unsigned MASK_BITS = 4;

  // slot age saturates here
  localparam logic [AGE_W-1:0] AGE_TOP = 32'hFFFF_FFFF;

  // action codes
  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // add status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_CHAN  = 2'd1,
    STAT_DISABLED = 2'd2,
    STAT_FULL     = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_RESP,
    S_SCAN,
    S_FETCH,
    S_EMIT
  } state_e;

  // request record as kept in the payload memory
  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  count;
    logic [15:0] start;
    logic [7:0]  slave;
    logic [15:0] handle;
  } req_t;

endpackage

// ===== sv/multichannel_oldest_first_request_pool.sv =====
// Add: a refused add goes straight to its result word; else the lowest free slot is searched from slot 0
// and filled if one is free. Tick: an aging scan over every slot, then one result word per channel in order.
// A stalled result word holds the sequencer until it is taken.
// One word at a time; a shared age compare walks the metadata RAM one slot a cycle.
// Reset (async, active low) empties every slot and clears the per-channel counts at once;
// slot RAM contents are only read for busy slots and need no clearing.
module multichannel_oldest_first_request_pool #(
  parameter int unsigned SLOTS    = 16,
  parameter int unsigned CHANNELS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [3:0]  channel_i,
  input  logic [3:0]  entry_kind_i,
  input  logic [7:0]  word_count_i,
  input  logic [15:0] start_address_i,
  input  logic [7:0]  slave_address_i,
  input  logic [15:0] data_handle_i,
  input  logic [3:0]  enabled_mask_i,
  input  logic [3:0]  ready_mask_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  add_status_o,
  output logic        dispatched_o,
  output logic [2:0]  out_channel_o,
  output logic [3:0]  out_kind_o,
  output logic [7:0]  out_count_o,
  output logic [15:0] out_start_o,
  output logic [7:0]  out_slave_o,
  output logic [15:0] out_handle_o,
  output logic        last_o
);

  localparam int unsigned SW     = $clog2(SLOTS);
  localparam int unsigned CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned QUOTA  = SLOTS / CHANNELS;
  localparam int unsigned PW     = $clog2(QUOTA + 1);
  localparam int unsigned META_W = CW + 1 + mofrp_pkg::AGE_W;

  mofrp_pkg::state_e  state_q, state_d;
  mofrp_pkg::status_e status_q, status_d, add_stat;

  logic [SLOTS-1:0]          busy_q;
  logic [PW-1:0]             pend_q [CHANNELS];
  logic [mofrp_pkg::AGE_W-1:0] best_q [CHANNELS];
  logic [SW-1:0]             pick_q [CHANNELS];
  logic [CHANNELS-1:0]       found_q;

  logic [SW:0]   idx_q, idx_d;
  logic          proc_v_q, proc_v_d;
  logic [SW-1:0] proc_idx_q;
  logic [CW-1:0] chan_q, chan_d;
  logic [CW-1:0] add_ch_q;
  mofrp_pkg::req_t req_q;
  logic [3:0]    en_q, rdy_q;

  logic accept, out_free;
  logic find_hit, resp_load, emit_load, start_tick;
  logic ch_ok, en_ok, quota_full;

  // slot metadata {channel, nonzero size, age}
  logic              meta_we;
  logic [SW-1:0]     meta_waddr;
  logic [META_W-1:0] meta_wdata, meta_rdata;
  logic [CW-1:0]     meta_ch;
  logic              meta_nz;
  logic [mofrp_pkg::AGE_W-1:0] meta_age, age_inc;
  logic              scan_busy, scan_better;

  mofrp_pkg::req_t pay_rdata;

  logic [mofrp_pkg::OUT_CH_W-1:0] chan_w;
  logic elig, chan_last;

  // output register
  logic        out_valid_q;
  logic [1:0]  out_status_q;
  logic        out_disp_q;
  logic [2:0]  out_ch_q;
  mofrp_pkg::req_t out_req_q;
  logic        out_last_q;

  assign in_stall_o = (state_q != mofrp_pkg::S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // add checks on the incoming word
  assign ch_ok      = channel_i < 4'(CHANNELS);
  assign en_ok      = (channel_i < 4'(mofrp_pkg::MASK_BITS)) && enabled_mask_i[channel_i[1:0]];
  assign quota_full = pend_q[channel_i[CW-1:0]] >= PW'(QUOTA);

  always_comb begin
    if (!ch_ok) begin
      add_stat = mofrp_pkg::STAT_NO_CHAN;
    end else if (!en_ok) begin
      add_stat = mofrp_pkg::STAT_DISABLED;
    end else if (quota_full) begin
      add_stat = mofrp_pkg::STAT_FULL;
    end else begin
      add_stat = mofrp_pkg::STAT_OK;
    end
  end

  // per-channel dispatch decision
  assign chan_w    = mofrp_pkg::OUT_CH_W'(chan_q);
  assign chan_last = (chan_q == CW'(CHANNELS - 1));
  assign elig      = found_q[chan_q] && (chan_w < mofrp_pkg::OUT_CH_W'(mofrp_pkg::MASK_BITS))
                     && rdy_q[chan_w[1:0]] && en_q[chan_w[1:0]];

  // sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mofrp_pkg::S_IDLE;
      proc_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      proc_v_q <= proc_v_d;
    end
  end

  // next state and strobes
  always_comb begin
    state_d    = state_q;
    status_d   = status_q;
    idx_d      = idx_q;
    chan_d     = chan_q;
    proc_v_d   = 1'b0;
    find_hit   = 1'b0;
    resp_load  = 1'b0;
    emit_load  = 1'b0;
    start_tick = 1'b0;
    case (state_q)
      mofrp_pkg::S_IDLE: begin
        if (accept) begin
          idx_d = '0;
          if (action_i == mofrp_pkg::ACT_TICK) begin
            start_tick = 1'b1;
            state_d    = mofrp_pkg::S_SCAN;
          end else begin
            status_d = add_stat;
            state_d  = (add_stat == mofrp_pkg::STAT_OK) ? mofrp_pkg::S_FIND
                                                         : mofrp_pkg::S_RESP;
          end
        end
      end
      mofrp_pkg::S_FIND: begin
        if (!busy_q[idx_q[SW-1:0]]) begin
          find_hit = 1'b1;
          state_d  = mofrp_pkg::S_RESP;
        end else if (idx_q[SW-1:0] == SW'(SLOTS - 1)) begin
          status_d = mofrp_pkg::STAT_FULL;
          state_d  = mofrp_pkg::S_RESP;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      mofrp_pkg::S_RESP: begin
        if (out_free) begin
          resp_load = 1'b1;
          state_d   = mofrp_pkg::S_IDLE;
        end
      end
      mofrp_pkg::S_SCAN: begin
        if (idx_q == (SW + 1)'(SLOTS)) begin
          chan_d  = '0;
          state_d = mofrp_pkg::S_FETCH;
        end else begin
          proc_v_d = 1'b1;
          idx_d    = idx_q + 1'b1;
        end
      end
      mofrp_pkg::S_FETCH: begin
        state_d = mofrp_pkg::S_EMIT;
      end
      mofrp_pkg::S_EMIT: begin
        if (out_free) begin
          emit_load = 1'b1;
          if (chan_last) begin
            state_d = mofrp_pkg::S_IDLE;
          end else begin
            chan_d  = chan_q + 1'b1;
            state_d = mofrp_pkg::S_FETCH;
          end
        end
      end
      default: begin
        state_d = mofrp_pkg::S_IDLE;
      end
    endcase
  end

  // sequencer working registers
  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    idx_q      <= idx_d;
    chan_q     <= chan_d;
    proc_idx_q <= idx_q[SW-1:0];
    if (accept) begin
      add_ch_q     <= channel_i[CW-1:0];
      req_q.kind   <= entry_kind_i;
      req_q.count  <= word_count_i;
      req_q.start  <= start_address_i;
      req_q.slave  <= slave_address_i;
      req_q.handle <= data_handle_i;
      en_q         <= enabled_mask_i;
      rdy_q        <= ready_mask_i;
    end
  end

  // shared aging and oldest-slot compare
  assign {meta_ch, meta_nz, meta_age} = meta_rdata;
  assign age_inc     = (meta_age == mofrp_pkg::AGE_TOP) ? meta_age : meta_age + 1'b1;
  assign scan_busy   = proc_v_q && busy_q[proc_idx_q];
  assign scan_better = meta_nz && (age_inc >= best_q[meta_ch]);

  assign meta_we    = find_hit || scan_busy;
  assign meta_waddr = find_hit ? idx_q[SW-1:0] : proc_idx_q;
  assign meta_wdata = find_hit ? {add_ch_q, (req_q.count != 8'd0), {mofrp_pkg::AGE_W{1'b0}}}
                               : {meta_ch, meta_nz, age_inc};

  mofrp_ram #(
    .WIDTH(META_W),
    .DEPTH(SLOTS)
  ) u_meta_ram (
    .clk_i  (clk_i),
    .we_i   (meta_we),
    .waddr_i(meta_waddr),
    .wdata_i(meta_wdata),
    .raddr_i(idx_q[SW-1:0]),
    .rdata_o(meta_rdata)
  );

  mofrp_ram #(
    .WIDTH($bits(mofrp_pkg::req_t)),
    .DEPTH(SLOTS)
  ) u_pay_ram (
    .clk_i  (clk_i),
    .we_i   (find_hit),
    .waddr_i(idx_q[SW-1:0]),
    .wdata_i(req_q),
    .raddr_i(pick_q[chan_q]),
    .rdata_o(pay_rdata)
  );

  // best candidate per channel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= '0;
    end else if (start_tick) begin
      found_q <= '0;
    end else if (scan_busy && scan_better) begin
      found_q[meta_ch] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_tick) begin
      for (int c = 0; c < CHANNELS; c++) begin
        best_q[c] <= '0;
      end
    end else if (scan_busy && scan_better) begin
      best_q[meta_ch] <= age_inc;
      pick_q[meta_ch] <= proc_idx_q;
    end
  end

  // slot occupancy and per-channel counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        pend_q[c] <= '0;
      end
    end else begin
      if (find_hit) begin
        busy_q[idx_q[SW-1:0]] <= 1'b1;
        pend_q[add_ch_q]      <= pend_q[add_ch_q] + 1'b1;
      end
      if (emit_load && elig) begin
        busy_q[pick_q[chan_q]] <= 1'b0;
        pend_q[chan_q]         <= pend_q[chan_q] - 1'b1;
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (resp_load || emit_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp_load) begin
      out_status_q <= status_q;
      out_disp_q   <= 1'b0;
      out_ch_q     <= '0;
      out_req_q    <= '0;
      out_last_q   <= 1'b1;
    end else if (emit_load) begin
      out_status_q <= mofrp_pkg::STAT_OK;
      out_disp_q   <= elig;
      out_ch_q     <= chan_w;
      out_req_q    <= elig ? pay_rdata : '0;
      out_last_q   <= chan_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign add_status_o  = out_status_q;
  assign dispatched_o  = out_disp_q;
  assign out_channel_o = out_ch_q;
  assign out_kind_o    = out_req_q.kind;
  assign out_count_o   = out_req_q.count;
  assign out_start_o   = out_req_q.start;
  assign out_slave_o   = out_req_q.slave;
  assign out_handle_o  = out_req_q.handle;
  assign last_o        = out_last_q;

endmodule

// ===== sv/mofrp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for slot metadata and slot payload of the request pool.
// No dependencies.
module mofrp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/mofrp_checker.sv =====
// Port-level checker for the multichannel oldest-first request pool.
// Bound to the top level below; uses no package.
module mofrp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  add_status_o,
  input logic        dispatched_o,
  input logic [2:0]  out_channel_o,
  input logic [3:0]  out_kind_o,
  input logic [7:0]  out_count_o,
  input logic [15:0] out_start_o,
  input logic [7:0]  out_slave_o,
  input logic [15:0] out_handle_o,
  input logic        last_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(add_status_o)
      && $stable(dispatched_o) && $stable(out_channel_o) && $stable(out_kind_o)
      && $stable(out_count_o) && $stable(out_start_o) && $stable(out_slave_o)
      && $stable(out_handle_o) && $stable(last_o))
    else $error("stalled result word changed");

  // one word in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while previous word still in work");

  // a rejected add is a single final word with nothing dispatched
  a_reject_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (add_status_o != 2'd0) |-> last_o && !dispatched_o)
    else $error("rejected add word malformed");

  // zero-size requests are never handed out
  a_disp_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dispatched_o |-> (out_count_o != 8'd0))
    else $error("dispatched request of zero size");

endmodule

bind multichannel_oldest_first_request_pool mofrp_checker u_mofrp_checker (.*);
